@@ rtl/mol_pkg.sv @@
package mol_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int CMD_W       = 16;
  localparam int VAL_W       = 18;
  localparam int PULSE_W     = 12;
  localparam int COUNT_W     = 16;
  localparam int DIV_W       = 32;
  localparam int DEN_W       = 17;
  localparam int ADDR_W      = 5;

  localparam logic [2:0] REG_MOTOR_MIN    = 3'd0;
  localparam logic [2:0] REG_MOTOR_MAX    = 3'd1;
  localparam logic [2:0] REG_PULSE_MIN    = 3'd2;
  localparam logic [2:0] REG_PULSE_MAX    = 3'd3;
  localparam logic [2:0] REG_PERIOD_COUNT = 3'd4;
  localparam logic [2:0] REG_FRAME_UNITS  = 3'd5;

  localparam logic signed [CMD_W-1:0] MOTOR_MIN_RST    = 16'sd0;
  localparam logic signed [CMD_W-1:0] MOTOR_MAX_RST    = 16'sd1000;
  localparam logic [PULSE_W-1:0]      PULSE_MIN_RST    = 12'd1250;
  localparam logic [PULSE_W-1:0]      PULSE_MAX_RST    = 12'd2500;
  localparam logic [COUNT_W-1:0]      PERIOD_COUNT_RST = 16'd60000;
  localparam logic [COUNT_W-1:0]      FRAME_UNITS_RST  = 16'd15000;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 16'hFFFF;

  typedef struct packed {
    logic [MOTOR_COUNT-1:0][VAL_W-1:0] val;
    logic                              shifted;
  } mol_item_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] motor_min;
    logic signed [CMD_W-1:0] motor_max;
    logic [PULSE_W-1:0]      pulse_min;
    logic [PULSE_W-1:0]      pulse_max;
    logic [COUNT_W-1:0]      period_count;
    logic [COUNT_W-1:0]      frame_units;
  } mol_cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } mol_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } mol_div_rsp_t;

endpackage

@@ rtl/mol_ifs.sv @@
interface mol_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] motor_a;
  logic signed [15:0] motor_b;
  logic signed [15:0] motor_c;
  logic signed [15:0] motor_d;
  modport source (output valid, motor_a, motor_b, motor_c, motor_d, input ready);
  modport sink (input valid, motor_a, motor_b, motor_c, motor_d, output ready);
endinterface

interface mol_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] width_a;
  logic [15:0] width_b;
  logic [15:0] width_c;
  logic [15:0] width_d;
  logic        shifted;
  modport source (output valid, width_a, width_b, width_c, width_d, shifted, input ready);
  modport sink (input valid, width_a, width_b, width_c, width_d, shifted, output ready);
endinterface

@@ rtl/motor_output_limit_and_pulse_map_unit.sv @@
// motor output limiter and pulse mapper
// in_ch carries four signed motor commands, out_ch four pwm compare counts
// and the shifted flag; both use valid/ready, a word moves when both are high
// configuration goes through the apb port: motor_min at 0x00, motor_max 0x04,
// pulse_min 0x08, pulse_max 0x0c, period_count 0x10, frame_units 0x14
// write registers only while no word is in flight
// the front stage takes the overshoot off all four commands in the cycle a
// word is accepted and pushes it into a QUEUE_DEPTH entry queue
// the back stage handles one motor at a time through one shared 32 step
// divider, two divides per motor, and takes the next word from the queue
// only after the last result has entered the output register; equal motor
// limits or zero frame_units skip a divide
// input is taken while the queue has room, also while a result waits
// a stalled receiver holds the result in the output register; the back stage
// then waits and the queue fills, after which in_ch.ready drops
// reset empties the queue, drops out_ch.valid and loads the default registers
module motor_output_limit_and_pulse_map_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mol_in_if.sink                       in_ch,
  mol_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mol_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mol_pkg::*;

  mol_cfg_t     cfg_r;
  mol_item_t    push_item, head_item;
  logic         push, pop, full, empty;
  mol_div_req_t div_req;
  mol_div_rsp_t div_rsp;
  logic [2:0]   ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motor_min    <= MOTOR_MIN_RST;
      cfg_r.motor_max    <= MOTOR_MAX_RST;
      cfg_r.pulse_min    <= PULSE_MIN_RST;
      cfg_r.pulse_max    <= PULSE_MAX_RST;
      cfg_r.period_count <= PERIOD_COUNT_RST;
      cfg_r.frame_units  <= FRAME_UNITS_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        REG_MOTOR_MIN:    cfg_r.motor_min    <= pwdata[15:0];
        REG_MOTOR_MAX:    cfg_r.motor_max    <= pwdata[15:0];
        REG_PULSE_MIN:    cfg_r.pulse_min    <= pwdata[11:0];
        REG_PULSE_MAX:    cfg_r.pulse_max    <= pwdata[11:0];
        REG_PERIOD_COUNT: cfg_r.period_count <= pwdata[15:0];
        REG_FRAME_UNITS:  cfg_r.frame_units  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (ridx)
      REG_MOTOR_MIN:    prdata = {16'd0, cfg_r.motor_min};
      REG_MOTOR_MAX:    prdata = {16'd0, cfg_r.motor_max};
      REG_PULSE_MIN:    prdata = {20'd0, cfg_r.pulse_min};
      REG_PULSE_MAX:    prdata = {20'd0, cfg_r.pulse_max};
      REG_PERIOD_COUNT: prdata = {16'd0, cfg_r.period_count};
      REG_FRAME_UNITS:  prdata = {16'd0, cfg_r.frame_units};
      default:          prdata = '0;
    endcase
  end

  mol_front u_front (
    .in_ch     (in_ch),
    .motor_max (cfg_r.motor_max),
    .full      (full),
    .push      (push),
    .item      (push_item)
  );

  mol_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(mol_item_t))
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_item),
    .pop   (pop),
    .rdata (head_item),
    .full  (full),
    .empty (empty)
  );

  mol_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  mol_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .empty   (empty),
    .item    (head_item),
    .pop     (pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );
endmodule

@@ rtl/mol_fifo.sv @@
module mol_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end
endmodule

@@ rtl/mol_front.sv @@
module mol_front (
  mol_in_if.sink                  in_ch,
  input  logic signed [15:0]      motor_max,
  input  logic                    full,
  output logic                    push,
  output mol_pkg::mol_item_t      item
);
  import mol_pkg::*;

  logic signed [VAL_W-1:0] v   [MOTOR_COUNT];
  logic signed [VAL_W-1:0] top;
  logic signed [VAL_W-1:0] lim;
  logic signed [VAL_W-1:0] over;
  logic                    shift;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  assign v[0] = VAL_W'(in_ch.motor_a);
  assign v[1] = VAL_W'(in_ch.motor_b);
  assign v[2] = VAL_W'(in_ch.motor_c);
  assign v[3] = VAL_W'(in_ch.motor_d);
  assign lim  = VAL_W'(motor_max);

  always_comb begin
    top = v[0];
    for (int i = 1; i < MOTOR_COUNT; i++) begin
      if (v[i] > top) begin
        top = v[i];
      end
    end
    shift = (top > lim);
    over  = shift ? (top - lim) : '0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      item.val[i] = v[i] - over;
    end
    item.shifted = shift;
  end
endmodule

@@ rtl/mol_div.sv @@
module mol_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mol_pkg::mol_div_req_t req,
  output mol_pkg::mol_div_rsp_t rsp
);
  import mol_pkg::*;

  logic [DIV_W-1:0] dq_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [DEN_W:0]   rem_sh;
  logic [4:0]       cnt_r;
  logic             busy_r, done_r;

  assign rem_sh       = {rem_r, dq_r[DIV_W-1]};
  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq_r  <= req.dividend;
      den_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= DEN_W'(rem_sh - {1'b0, den_r});
        dq_r  <= {dq_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DEN_W-1:0];
        dq_r  <= {dq_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/mol_back.sv @@
module mol_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mol_pkg::mol_cfg_t     cfg,
  input  logic                  empty,
  input  mol_pkg::mol_item_t    item,
  output logic                  pop,
  output mol_pkg::mol_div_req_t div_req,
  input  mol_pkg::mol_div_rsp_t div_rsp,
  mol_out_if.source             out_ch
);
  import mol_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL1   = 9'b000000010,
    S_START1 = 9'b000000100,
    S_DIV1   = 9'b000001000,
    S_MAP    = 9'b000010000,
    S_MUL2   = 9'b000100000,
    S_START2 = 9'b001000000,
    S_DIV2   = 9'b010000000,
    S_OUT    = 9'b100000000
  } mol_state_t;

  localparam int IW = $clog2(MOTOR_COUNT);

  mol_state_t              state_r, state_nxt;
  mol_item_t               item_r;
  logic [IW-1:0]           idx_r;
  logic signed [31:0]      prod_r;
  logic [27:0]             prod2_r;
  logic                    neg_r;
  logic [PULSE_W-1:0]      pulse_r;
  logic [COUNT_W-1:0]      w_r [MOTOR_COUNT];
  logic                    ov_r;
  logic [COUNT_W-1:0]      ow_r [MOTOR_COUNT];
  logic                    osh_r;

  logic signed [VAL_W-1:0] x;
  logic signed [18:0]      diff;
  logic signed [12:0]      dp;
  logic signed [DEN_W-1:0] den;
  logic                    same;
  logic signed [32:0]      qs, val, pmin_s, pmax_s;
  logic                    out_free;

  assign x        = item_r.val[idx_r];
  assign diff     = 19'(x) - 19'(cfg.motor_min);
  assign dp       = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});
  assign den      = DEN_W'(cfg.motor_max) - DEN_W'(cfg.motor_min);
  assign same     = (cfg.motor_max == cfg.motor_min);
  assign pmin_s   = $signed({21'd0, cfg.pulse_min});
  assign pmax_s   = $signed({21'd0, cfg.pulse_max});
  assign qs       = neg_r ? -$signed({1'b0, div_rsp.quotient})
                          : $signed({1'b0, div_rsp.quotient});
  assign val      = qs + pmin_s;
  assign out_free = !ov_r || out_ch.ready;
  assign pop      = (state_r == S_IDLE) && !empty;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (state_r == S_START1) begin
      div_req.start    = 1'b1;
      div_req.dividend = prod_r[31] ? DIV_W'(-prod_r) : DIV_W'(prod_r);
      div_req.divisor  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    end else if (state_r == S_START2) begin
      div_req.start    = 1'b1;
      div_req.dividend = {4'd0, prod2_r};
      div_req.divisor  = {1'b0, cfg.frame_units};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (!empty) state_nxt = S_MUL1;
      S_MUL1:   state_nxt = same ? S_MUL2 : S_START1;
      S_START1: state_nxt = S_DIV1;
      S_DIV1:   if (div_rsp.done) state_nxt = S_MAP;
      S_MAP:    state_nxt = S_MUL2;
      S_MUL2: begin
        if (cfg.frame_units == '0) begin
          state_nxt = (idx_r == IW'(MOTOR_COUNT - 1)) ? S_OUT : S_MUL1;
        end else begin
          state_nxt = S_START2;
        end
      end
      S_START2: state_nxt = S_DIV2;
      S_DIV2: begin
        if (div_rsp.done) begin
          state_nxt = (idx_r == IW'(MOTOR_COUNT - 1)) ? S_OUT : S_MUL1;
        end
      end
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) begin
        idx_r <= '0;
      end else if ((state_r == S_DIV2 && div_rsp.done) ||
                   (state_r == S_MUL2 && cfg.frame_units == '0)) begin
        idx_r <= idx_r + IW'(1);
      end
      if (state_r == S_OUT && out_free) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= item;
    end
    if (state_r == S_MUL1) begin
      prod_r <= 32'(diff) * 32'(dp);
      if (same) begin
        pulse_r <= cfg.pulse_min;
      end
    end
    if (state_r == S_START1) begin
      neg_r <= prod_r[31] ^ den[DEN_W-1];
    end
    if (state_r == S_MAP) begin
      if (val < pmin_s) begin
        pulse_r <= cfg.pulse_min;
      end else if (val > pmax_s) begin
        pulse_r <= cfg.pulse_max;
      end else begin
        pulse_r <= val[PULSE_W-1:0];
      end
    end
    if (state_r == S_MUL2) begin
      prod2_r <= 28'(cfg.period_count) * 28'(pulse_r);
      if (cfg.frame_units == '0) begin
        w_r[idx_r] <= COUNT_SAT;
      end
    end
    if (state_r == S_DIV2 && div_rsp.done) begin
      w_r[idx_r] <= (div_rsp.quotient[DIV_W-1:COUNT_W] != '0) ? COUNT_SAT
                                                             : div_rsp.quotient[COUNT_W-1:0];
    end
    if (state_r == S_OUT && out_free) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        ow_r[i] <= w_r[i];
      end
      osh_r <= item_r.shifted;
    end
  end

  assign out_ch.valid   = ov_r;
  assign out_ch.width_a = ow_r[0];
  assign out_ch.width_b = ow_r[1];
  assign out_ch.width_c = ow_r[2];
  assign out_ch.width_d = ow_r[3];
  assign out_ch.shifted = osh_r;
endmodule

@@ rtl/mol_checker.sv @@
module mol_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] width_a,
  input logic        shifted
);
  logic [7:0] pend_r;
  logic       in_take, out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_take && !out_take) begin
      pend_r <= pend_r + 8'd1;
    end else if (out_take && !in_take) begin
      pend_r <= pend_r - 8'd1;
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 8'd0))
    else $error("result with no word pending");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(width_a) && $stable(shifted)))
    else $error("result changed while stalled");
endmodule

bind motor_output_limit_and_pulse_map_unit mol_checker u_mol_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .width_a   (out_ch.width_a),
  .shifted   (out_ch.shifted)
);
